[rtl/pwb_pkg.sv]
// Shared types, codes and the gaussian weight ROM of the padded window blur filter.
package pwb_pkg;

  localparam int DIM_W      = 13;
  localparam int SLOT_W     = 5;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int ROM_W      = 25;
  localparam int ROM_FRAC   = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_RAD_X,
    REG_RAD_Y,
    REG_PAD,
    REG_FILTER
  } reg_idx_t;

  typedef enum logic [1:0] {
    PAD_ZERO,
    PAD_MIRROR,
    PAD_REPL
  } pad_t;

  typedef enum logic {
    OP_PIXEL,
    OP_DRAIN
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [3:0]       rad_x;
    logic [3:0]       rad_y;
    logic [1:0]       pad;
    logic             gauss;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [DIM_W-1:0]  col;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } res_t;

  function automatic logic [ROM_W-1:0] gauss_rom(input logic [8:0] d);
    logic [ROM_W-1:0] v;
    case (d)
      9'd0:  v = 25'd16777216;
      9'd1:  v = 25'd10175896;
      9'd2:  v = 25'd6171993;
      9'd3:  v = 25'd3743503;
      9'd4:  v = 25'd2270549;
      9'd5:  v = 25'd1377158;
      9'd6:  v = 25'd835288;
      9'd7:  v = 25'd506628;
      9'd8:  v = 25'd307285;
      9'd9:  v = 25'd186378;
      9'd10: v = 25'd113044;
      9'd11: v = 25'd68565;
      9'd12: v = 25'd41587;
      9'd13: v = 25'd25224;
      9'd14: v = 25'd15297;
      9'd15: v = 25'd9279;
      9'd16: v = 25'd5628;
      9'd17: v = 25'd3414;
      9'd18: v = 25'd2070;
      9'd19: v = 25'd1256;
      9'd20: v = 25'd762;
      9'd21: v = 25'd462;
      9'd22: v = 25'd280;
      9'd23: v = 25'd170;
      9'd24: v = 25'd103;
      9'd25: v = 25'd63;
      9'd26: v = 25'd38;
      9'd27: v = 25'd23;
      9'd28: v = 25'd14;
      9'd29: v = 25'd8;
      9'd30: v = 25'd5;
      9'd31: v = 25'd3;
      9'd32: v = 25'd2;
      9'd33: v = 25'd1;
      9'd34: v = 25'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/pwb_front.sv]
// Front end: accepts items, tracks input and output positions, issues store writes and jobs.
module pwb_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  pwb_pkg::cfg_t cfg,
  input  logic          cfg_clear,
  input  logic          push,
  output logic          full,
  input  logic          operation,
  input  logic [7:0]    pixel_in,
  output pwb_pkg::wr_t  wr,
  output logic          job_valid,
  output pwb_pkg::job_t job,
  input  logic          job_take,
  input  logic          eng_idle
);

  localparam int CW_C       = $clog2(MAX_WIDTH + 1);
  localparam int CW_R       = $clog2(MAX_HEIGHT + 1);
  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int SW         = $clog2(STORE_ROWS);

  logic [CW_C-1:0] w, wm1, in_col, col_next, out_col, nc;
  logic [CW_R-1:0] h, hm1, in_row, row_next, out_row, nr;
  logic [SW-1:0]   in_slot, slot_next, out_slot;
  logic [CW_C:0]   col_inc, nc_sum, out_col_inc;
  logic [CW_R:0]   nr_sum;
  logic            accept, pix, emit, is_last;

  always_comb begin
    w       = cfg.width[CW_C-1:0];
    h       = cfg.height[CW_R-1:0];
    wm1     = w - 1'b1;
    hm1     = h - 1'b1;
    accept  = push && !full;
    pix     = accept && (operation == pwb_pkg::OP_PIXEL) && (in_row < h);
    col_inc = {1'b0, in_col} + 1'b1;
    row_next  = in_row;
    col_next  = in_col;
    slot_next = in_slot;
    if (pix) begin
      if (col_inc >= {1'b0, w}) begin
        col_next  = '0;
        row_next  = in_row + 1'b1;
        slot_next = (in_slot == SW'(STORE_ROWS - 1)) ? '0 : in_slot + 1'b1;
      end else begin
        col_next = col_inc[CW_C-1:0];
      end
    end
    nr_sum  = {1'b0, out_row} + (CW_R + 1)'(cfg.rad_y);
    nc_sum  = {1'b0, out_col} + (CW_C + 1)'(cfg.rad_x);
    nr      = (nr_sum < {1'b0, hm1}) ? nr_sum[CW_R-1:0] : hm1;
    nc      = (nc_sum < {1'b0, wm1}) ? nc_sum[CW_C-1:0] : wm1;
    emit    = accept && ((row_next > nr) || ((row_next == nr) && (col_next > nc)));
    is_last = (out_row == hm1) && (out_col == wm1);
    out_col_inc = {1'b0, out_col} + 1'b1;
    full    = job_valid || !eng_idle;
    wr.en   = pix;
    wr.slot = pwb_pkg::SLOT_W'(in_slot);
    wr.col  = pwb_pkg::DIM_W'(in_col);
    wr.data = pixel_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row    <= '0;
      in_col    <= '0;
      in_slot   <= '0;
      out_row   <= '0;
      out_col   <= '0;
      out_slot  <= '0;
      job_valid <= 1'b0;
    end else begin
      if (job_take) begin
        job_valid <= 1'b0;
      end
      if (cfg_clear) begin
        in_row   <= '0;
        in_col   <= '0;
        in_slot  <= '0;
        out_row  <= '0;
        out_col  <= '0;
        out_slot <= '0;
      end else if (accept) begin
        in_row  <= row_next;
        in_col  <= col_next;
        in_slot <= slot_next;
        if (emit) begin
          job_valid <= 1'b1;
          job.row   <= pwb_pkg::DIM_W'(out_row);
          job.col   <= pwb_pkg::DIM_W'(out_col);
          job.slot  <= pwb_pkg::SLOT_W'(out_slot);
          job.last  <= is_last;
          if (is_last) begin
            in_row   <= '0;
            in_col   <= '0;
            in_slot  <= '0;
            out_row  <= '0;
            out_col  <= '0;
            out_slot <= '0;
          end else if (out_col_inc >= {1'b0, w}) begin
            out_col  <= '0;
            out_row  <= out_row + 1'b1;
            out_slot <= (out_slot == SW'(STORE_ROWS - 1)) ? '0 : out_slot + 1'b1;
          end else begin
            out_col <= out_col_inc[CW_C-1:0];
          end
        end
      end
    end
  end

endmodule

[rtl/pwb_engine.sv]
// Back end: line store, window tap sequencer, multiply-accumulate, divider and rounding.
module pwb_engine #(
  parameter int MAX_WIDTH        = 1024,
  parameter int MAX_HEIGHT       = 1024,
  parameter int MAX_RADIUS       = 9,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  pwb_pkg::cfg_t cfg,
  input  pwb_pkg::wr_t  wr,
  input  logic          job_valid,
  input  pwb_pkg::job_t job,
  output logic          job_take,
  output logic          eng_idle,
  output logic          res_push,
  output pwb_pkg::res_t res,
  input  logic          res_full
);

  localparam int CW_C       = $clog2(MAX_WIDTH + 1);
  localparam int CW_R       = $clog2(MAX_HEIGHT + 1);
  localparam int PW         = ((CW_C > CW_R) ? CW_C : CW_R) + 2;
  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int SW         = $clog2(STORE_ROWS);
  localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
  localparam int AW         = $clog2(DEPTH);
  localparam int FB         = (WEIGHT_FRAC_BITS > 24) ? 24 : WEIGHT_FRAC_BITS;
  localparam int SHIFT      = pwb_pkg::ROM_FRAC - FB;
  localparam int HALF       = (1 << SHIFT) >> 1;
  localparam int WW         = FB + 1;
  localparam int TAPS       = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int LW         = $clog2(TAPS + 1);
  localparam int WS_W       = WW + LW;
  localparam int ACC_W      = WS_W + 8;

  typedef enum logic [2:0] {
    E_IDLE,
    E_TAPS,
    E_FLUSH,
    E_DIV,
    E_ROUND,
    E_PUSH
  } state_t;

  state_t state;

  logic [7:0]      mem [DEPTH];
  logic [7:0]      rd_data;
  logic [AW-1:0]   wr_addr, rd_addr;

  logic [CW_R-1:0] j_row;
  logic [CW_C-1:0] j_col;
  logic [SW-1:0]   j_slot;
  logic            j_last;
  logic signed [4:0] ti, tj, rx_s, ry_s;

  logic                 s1_v, s1_zero, s2_v, s2_zero;
  logic [WW-1:0]        s1_wt, s2_wt;
  logic [SW-1:0]        s1_slot;
  logic [CW_C-1:0]      s1_col;

  logic [ACC_W-1:0] acc, rem, dsor;
  logic [WS_W-1:0]  ws;
  logic [8:0]       quo;
  logic [3:0]       cnt;

  logic signed [PW-1:0] p_r, p_c, last_r, last_c, r_map, c_map, delta, slot_s;
  logic [PW:0]          mr, mc;
  logic                 tap_zero, last_tap;
  logic [SW-1:0]        tap_slot;
  logic [CW_C-1:0]      tap_col;
  logic signed [9:0]    sq_i, sq_j;
  logic [9:0]           dsum;
  logic [pwb_pkg::ROM_W:0] g_ext;
  logic [WW-1:0]        wt_g, tap_wt;
  logic [WW+7:0]        prod;
  logic                 round_up;
  logic [9:0]           q_round;

  function automatic logic [PW:0] map_coord(input logic signed [PW-1:0] p,
                                            input logic signed [PW-1:0] lst,
                                            input logic [1:0] mode);
    logic signed [PW-1:0] q;
    logic                 z;
    z = 1'b0;
    q = p;
    if (p < 0 || p > lst) begin
      case (mode)
        pwb_pkg::PAD_MIRROR: q = (p < 0) ? -p : (lst <<< 1) - p;
        pwb_pkg::PAD_REPL:   q = p;
        default: begin
          z = 1'b1;
          q = '0;
        end
      endcase
      if (q < 0) q = '0;
      if (q > lst) q = lst;
    end
    return {z, q};
  endfunction

  always_comb begin
    rx_s   = $signed({1'b0, cfg.rad_x});
    ry_s   = $signed({1'b0, cfg.rad_y});
    last_r = $signed(PW'(cfg.height)) - 1;
    last_c = $signed(PW'(cfg.width)) - 1;
    p_r    = $signed({{(PW - CW_R){1'b0}}, j_row}) + PW'(ti);
    p_c    = $signed({{(PW - CW_C){1'b0}}, j_col}) + PW'(tj);
    mr     = map_coord(p_r, last_r, cfg.pad);
    mc     = map_coord(p_c, last_c, cfg.pad);
    r_map  = $signed(mr[PW-1:0]);
    c_map  = $signed(mc[PW-1:0]);
    tap_zero = mr[PW] || mc[PW];
    delta  = r_map - $signed({{(PW - CW_R){1'b0}}, j_row});
    slot_s = $signed({{(PW - SW){1'b0}}, j_slot}) + delta;
    if (slot_s < 0) begin
      slot_s = slot_s + PW'(STORE_ROWS);
    end else if (slot_s >= PW'(STORE_ROWS)) begin
      slot_s = slot_s - PW'(STORE_ROWS);
    end
    tap_slot = slot_s[SW-1:0];
    tap_col  = c_map[CW_C-1:0];
    sq_i   = 10'(ti) * 10'(ti);
    sq_j   = 10'(tj) * 10'(tj);
    dsum   = 10'(sq_i + sq_j);
    g_ext  = {1'b0, pwb_pkg::gauss_rom(dsum[8:0])} + (pwb_pkg::ROM_W + 1)'(HALF);
    wt_g   = WW'(g_ext >> SHIFT);
    tap_wt = cfg.gauss ? wt_g : {1'b1, {FB{1'b0}}};
    last_tap = (ti == ry_s) && (tj == rx_s);
    prod     = WW'(s2_wt) * (WW + 8)'(rd_data);
    round_up = ({rem[WS_W-1:0], 1'b0} > {1'b0, ws}) ||
               (({rem[WS_W-1:0], 1'b0} == {1'b0, ws}) && quo[0]);
    q_round  = {1'b0, quo} + 10'(round_up);
    wr_addr  = AW'(int'(wr.slot) * MAX_WIDTH + int'(wr.col));
    rd_addr  = AW'(int'(s1_slot) * MAX_WIDTH + int'(s1_col));
    eng_idle = (state == E_IDLE);
    job_take = eng_idle && job_valid;
    res_push = (state == E_PUSH) && !res_full;
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
    end else begin
      s1_v    <= (state == E_TAPS);
      s1_zero <= tap_zero;
      s1_wt   <= tap_wt;
      s1_slot <= tap_slot;
      s1_col  <= tap_col;
      s2_v    <= s1_v;
      s2_zero <= s1_zero;
      s2_wt   <= s1_wt;
      if (s2_v) begin
        ws  <= ws + WS_W'(s2_wt);
        acc <= acc + (s2_zero ? '0 : ACC_W'(prod));
      end
      case (state)
        E_IDLE: begin
          if (job_valid) begin
            j_row  <= job.row[CW_R-1:0];
            j_col  <= job.col[CW_C-1:0];
            j_slot <= job.slot[SW-1:0];
            j_last <= job.last;
            ti     <= -ry_s;
            tj     <= -rx_s;
            acc    <= '0;
            ws     <= '0;
            state  <= E_TAPS;
          end
        end
        E_TAPS: begin
          if (tj == rx_s) begin
            tj <= -rx_s;
            ti <= ti + 1'b1;
          end else begin
            tj <= tj + 1'b1;
          end
          if (last_tap) begin
            state <= E_FLUSH;
          end
        end
        E_FLUSH: begin
          if (!s1_v && !s2_v) begin
            rem   <= acc;
            dsor  <= ACC_W'({ws, 8'b0});
            quo   <= '0;
            cnt   <= 4'd8;
            state <= E_DIV;
          end
        end
        E_DIV: begin
          if (rem >= dsor) begin
            rem <= rem - dsor;
            quo <= {quo[7:0], 1'b1};
          end else begin
            quo <= {quo[7:0], 1'b0};
          end
          dsor <= dsor >> 1;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= E_ROUND;
          end
        end
        E_ROUND: begin
          if (ws == '0) begin
            res.pixel <= '0;
          end else if (q_round > 10'd255) begin
            res.pixel <= 8'hFF;
          end else begin
            res.pixel <= q_round[7:0];
          end
          res.last <= j_last;
          state    <= E_PUSH;
        end
        E_PUSH: begin
          if (!res_full) begin
            state <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == E_ROUND) && (ws != '0) |-> (rem < ACC_W'(ws)))
    else $error("divider remainder not below weight sum");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> $past(s1_v))
    else $error("accumulate stage valid without read stage");

  a_push_ends: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (state == E_IDLE))
    else $error("engine did not return to idle after result");

  a_no_taps_idle: assert property (@(posedge clk) disable iff (rst)
    (state == E_DIV) |-> (!s1_v && !s2_v))
    else $error("taps still in flight during divide");

endmodule

[rtl/pwb_result_fifo.sv]
// Two-entry result queue between the engine and the output ports.
module pwb_result_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  pwb_pkg::res_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output pwb_pkg::res_t rd_data
);

  pwb_pkg::res_t store [2];
  logic          wp, rp;
  logic [1:0]    count;
  logic          do_wr, do_rd;

  always_comb begin
    full    = (count == 2'd2);
    empty   = (count == 2'd0);
    do_wr   = wr_en && !full;
    do_rd   = pop && !empty;
    rd_data = store[rp];
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (do_wr) wp <= !wp;
      if (do_rd) rp <= !rp;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

[rtl/padded_window_blur_filter_core.sv]
// Padded window blur filter: top level with configuration registers and unit wiring.
// Pixels stream in raster order and are accepted while no job is pending and the
// engine is idle. After a pixel that completes a window, further items wait while
// the engine walks every tap of the (2*radius_x+1) x (2*radius_y+1) window through
// the single line store read port, one tap a cycle, and then the read pipeline, the
// 9-step divider, rounding and a hand-off that waits while the result queue is full.
// Drain items flush the outputs still owed after the last pixel of a frame.
module padded_window_blur_filter_core #(
  parameter int MAX_WIDTH        = 1024,
  parameter int MAX_HEIGHT       = 1024,
  parameter int MAX_RADIUS       = 9,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pwb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic                            operation,
  input  logic [7:0]                      pixel_in,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      pixel_out,
  output logic                            last_of_frame
);

  logic [10:0]   width_reg, height_reg;
  logic [3:0]    rad_x_reg, rad_y_reg;
  logic [1:0]    pad_reg;
  logic          filter_reg;
  logic          cfg_clear;
  pwb_pkg::cfg_t cfg;
  pwb_pkg::wr_t  wr;
  pwb_pkg::job_t job;
  pwb_pkg::res_t res, res_head;
  logic          job_valid, job_take, eng_idle, res_push, res_full;

  always_comb begin
    case (cfg_index)
      pwb_pkg::REG_WIDTH, pwb_pkg::REG_HEIGHT, pwb_pkg::REG_RAD_X,
      pwb_pkg::REG_RAD_Y, pwb_pkg::REG_PAD, pwb_pkg::REG_FILTER: cfg_clear = cfg_we;
      default: cfg_clear = 1'b0;
    endcase
    if (width_reg == '0) begin
      cfg.width = pwb_pkg::DIM_W'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      cfg.width = pwb_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      cfg.width = pwb_pkg::DIM_W'(width_reg);
    end
    if (height_reg == '0) begin
      cfg.height = pwb_pkg::DIM_W'(1);
    end else if (32'(height_reg) > MAX_HEIGHT) begin
      cfg.height = pwb_pkg::DIM_W'(MAX_HEIGHT);
    end else begin
      cfg.height = pwb_pkg::DIM_W'(height_reg);
    end
    cfg.rad_x = (32'(rad_x_reg) > MAX_RADIUS) ? 4'(MAX_RADIUS) : rad_x_reg;
    cfg.rad_y = (32'(rad_y_reg) > MAX_RADIUS) ? 4'(MAX_RADIUS) : rad_y_reg;
    cfg.pad   = pad_reg;
    cfg.gauss = filter_reg;
    pixel_out     = res_head.pixel;
    last_of_frame = res_head.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 11'd1024;
      height_reg <= 11'd1024;
      rad_x_reg  <= 4'd9;
      rad_y_reg  <= 4'd9;
      pad_reg    <= pwb_pkg::PAD_MIRROR;
      filter_reg <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pwb_pkg::REG_WIDTH:  width_reg  <= cfg_data;
        pwb_pkg::REG_HEIGHT: height_reg <= cfg_data;
        pwb_pkg::REG_RAD_X:  rad_x_reg  <= cfg_data[3:0];
        pwb_pkg::REG_RAD_Y:  rad_y_reg  <= cfg_data[3:0];
        pwb_pkg::REG_PAD:    pad_reg    <= cfg_data[1:0];
        pwb_pkg::REG_FILTER: filter_reg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pwb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_clear (cfg_clear),
    .push      (push),
    .full      (full),
    .operation (operation),
    .pixel_in  (pixel_in),
    .wr        (wr),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .eng_idle  (eng_idle)
  );

  pwb_engine #(
    .MAX_WIDTH        (MAX_WIDTH),
    .MAX_HEIGHT       (MAX_HEIGHT),
    .MAX_RADIUS       (MAX_RADIUS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .wr        (wr),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .eng_idle  (eng_idle),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  pwb_result_fifo u_result_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .empty   (empty),
    .rd_data (res_head)
  );

endmodule
